FILE: hw/rtl/tia_pkg.sv
// Shared constants, codes and types of the table index allocator.
`default_nettype none
package tia_pkg;

    localparam int NUM_ENTRIES = 64;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int LIM_W       = $clog2(NUM_ENTRIES + 1);
    localparam int CFG_W       = 7;
    localparam int REQ_IDX_W   = 8;
    localparam int GRANT_W     = 6;
    localparam int STATUS_W    = 3;
    localparam int SEL_W       = (LIM_W > REQ_IDX_W) ? LIM_W : REQ_IDX_W;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = CFG_W'(64);

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_ENABLE  = 2'd2,
        REQ_DISABLE = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_IN_USE    = 3'd2,
        ST_FULL      = 3'd3,
        ST_EQ_NEEDED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CELL_NOP,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_CLAIM,
        CELL_FREE,
        CELL_EN_SET,
        CELL_EN_CLR
    } cell_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_EMIT
    } state_t;

    // Command broadcast to every cell of the row
    typedef struct packed {
        cell_op_t          op;
        logic [SEL_W-1:0]  sel;
    } cell_cmd_t;

    // OR-reduced answers of the row
    typedef struct packed {
        logic sel_in_use;
        logic sel_en;
        logic tok_free;
    } cell_sum_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tia_if.sv
// Request and response channel interfaces of the table index allocator.
`default_nettype none
interface tia_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic       req_any;
    logic [7:0] req_index;
    logic       flow_ctrl;
    logic       has_eq;
    logic       lists_busy;

    modport source (
        output valid, req_type, req_any, req_index, flow_ctrl, has_eq, lists_busy,
        input  ready
    );
    modport sink (
        input  valid, req_type, req_any, req_index, flow_ctrl, has_eq, lists_busy,
        output ready
    );
endinterface

interface tia_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [5:0] grant_index;
    logic       entry_enabled;

    modport source (
        output valid, status, grant_index, entry_enabled,
        input  ready
    );
    modport sink (
        input  valid, status, grant_index, entry_enabled,
        output ready
    );
endinterface
`default_nettype wire

FILE: hw/rtl/tia_cell.sv
// One table slot: in-use and enable bits plus the search token stage.
`default_nettype none
module tia_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [tia_pkg::IDX_W-1:0] cell_idx,
    input  wire logic [tia_pkg::LIM_W-1:0] lim,
    input  wire tia_pkg::cell_cmd_t        cmd,
    input  wire logic                      tok_in,
    output logic                           tok_fwd,
    output logic                           tok_wrap,
    output logic                           sel_in_use,
    output logic                           sel_en,
    output logic                           tok_free
);
    import tia_pkg::*;

    logic             in_use_reg, in_use_next;
    logic             en_reg, en_next;
    logic             tok_reg, tok_next;
    logic             match;
    logic [LIM_W-1:0] idx_plus1;

    assign match     = (cmd.sel == SEL_W'(cell_idx));
    assign idx_plus1 = LIM_W'(cell_idx) + LIM_W'(1);

    // token goes to the next cell, or back to slot 0 from the last slot below the limit
    assign tok_fwd    = tok_reg && (idx_plus1 < lim);
    assign tok_wrap   = tok_reg && (idx_plus1 >= lim);
    assign sel_in_use = match && in_use_reg;
    assign sel_en     = match && en_reg;
    assign tok_free   = tok_reg && !in_use_reg;

    always_comb
    begin
        in_use_next = in_use_reg;
        en_next     = en_reg;
        tok_next    = 1'b0;
        case (cmd.op)
            CELL_LOAD:   tok_next = match;
            CELL_SHIFT:  tok_next = tok_in;
            CELL_CLAIM:
            begin
                if (match)
                begin
                    in_use_next = 1'b1;
                    en_next     = 1'b1;
                end
            end
            CELL_FREE:
            begin
                if (match)
                begin
                    in_use_next = 1'b0;
                    en_next     = 1'b0;
                end
            end
            CELL_EN_SET:
            begin
                if (match)
                    en_next = 1'b1;
            end
            CELL_EN_CLR:
            begin
                if (match)
                    en_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= 1'b0;
            en_reg     <= 1'b0;
            tok_reg    <= 1'b0;
        end
        else
        begin
            in_use_reg <= in_use_next;
            en_reg     <= en_next;
            tok_reg    <= tok_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/tia_ctrl.sv
// Request sequencer: decodes items, drives the cell row, holds the output register.
`default_nettype none
module tia_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    tia_req_if.sink                        req,
    tia_rsp_if.source                      rsp,
    input  wire logic [tia_pkg::LIM_W-1:0] lim,
    input  wire tia_pkg::cell_sum_t        sum,
    output tia_pkg::cell_cmd_t             cmd
);
    import tia_pkg::*;

    state_t               state_reg, state_next;

    // captured item
    req_type_t            r_type_reg;
    logic                 r_any_reg;
    logic [REQ_IDX_W-1:0] r_index_reg;
    logic                 r_fc_reg;
    logic                 r_eq_reg;
    logic                 r_busy_reg;

    logic [IDX_W-1:0]     last_reg, last_next;
    logic                 granted_reg, granted_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [LIM_W-1:0]     cnt_reg, cnt_next;

    status_t              res_status_reg, res_status_next;
    logic [GRANT_W-1:0]   res_grant_reg, res_grant_next;
    logic                 res_en_reg, res_en_next;

    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic [GRANT_W-1:0]   out_grant_reg, out_grant_next;
    logic                 out_en_reg, out_en_next;

    logic                 idx_valid;
    logic                 rd_en;
    logic [LIM_W-1:0]     last_plus1;
    logic [LIM_W-1:0]     pos_plus1;
    logic [LIM_W-1:0]     cnt_plus1;
    logic [IDX_W-1:0]     scan_start;

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.grant_index   = out_grant_reg;
    assign rsp.entry_enabled = out_en_reg;

    assign idx_valid  = (SEL_W'(r_index_reg) < SEL_W'(lim));
    assign rd_en      = idx_valid && sum.sel_en;
    assign last_plus1 = LIM_W'(last_reg) + LIM_W'(1);
    assign pos_plus1  = LIM_W'(pos_reg) + LIM_W'(1);
    assign cnt_plus1  = cnt_reg + LIM_W'(1);
    assign scan_start = (granted_reg && (last_plus1 < lim)) ? IDX_W'(last_plus1) : '0;

    always_comb
    begin
        state_next      = state_reg;
        last_next       = last_reg;
        granted_next    = granted_reg;
        pos_next        = pos_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        res_en_next     = res_en_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_grant_next  = out_grant_reg;
        out_en_next     = out_en_reg;
        cmd.op          = CELL_NOP;
        cmd.sel         = SEL_W'(r_index_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                    state_next = S_EXEC;
            end

            S_EXEC:
            begin
                state_next      = S_EMIT;
                res_grant_next  = '0;
                if (r_type_reg == REQ_ALLOC)
                begin
                    if (r_fc_reg && !r_eq_reg)
                    begin
                        res_status_next = ST_EQ_NEEDED;
                        res_en_next     = rd_en;
                    end
                    else if (!r_any_reg)
                    begin
                        if (!idx_valid)
                        begin
                            res_status_next = ST_INVALID;
                            res_en_next     = 1'b0;
                        end
                        else if (sum.sel_in_use)
                        begin
                            res_status_next = ST_IN_USE;
                            res_en_next     = sum.sel_en;
                        end
                        else
                        begin
                            cmd.op          = CELL_CLAIM;
                            res_status_next = ST_OK;
                            res_grant_next  = GRANT_W'(r_index_reg);
                            res_en_next     = 1'b1;
                            last_next       = IDX_W'(r_index_reg);
                            granted_next    = 1'b1;
                        end
                    end
                    else if (lim == '0)
                    begin
                        res_status_next = ST_FULL;
                        res_en_next     = 1'b0;
                    end
                    else
                    begin
                        cmd.op     = CELL_LOAD;
                        cmd.sel    = SEL_W'(scan_start);
                        pos_next   = scan_start;
                        cnt_next   = '0;
                        state_next = S_SCAN;
                    end
                end
                else if (!idx_valid || !sum.sel_in_use)
                begin
                    res_status_next = ST_INVALID;
                    res_en_next     = rd_en;
                end
                else
                begin
                    case (r_type_reg)
                        REQ_FREE:
                        begin
                            if (r_busy_reg)
                            begin
                                res_status_next = ST_IN_USE;
                                res_en_next     = sum.sel_en;
                            end
                            else
                            begin
                                cmd.op          = CELL_FREE;
                                res_status_next = ST_OK;
                                res_en_next     = 1'b0;
                            end
                        end
                        REQ_ENABLE:
                        begin
                            cmd.op          = CELL_EN_SET;
                            res_status_next = ST_OK;
                            res_en_next     = 1'b1;
                        end
                        default:
                        begin
                            cmd.op          = CELL_EN_CLR;
                            res_status_next = ST_OK;
                            res_en_next     = 1'b0;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // token sits in the cell at pos_reg
                cmd.sel = SEL_W'(pos_reg);
                if (sum.tok_free)
                begin
                    cmd.op          = CELL_CLAIM;
                    res_status_next = ST_OK;
                    res_grant_next  = GRANT_W'(pos_reg);
                    res_en_next     = 1'b1;
                    last_next       = pos_reg;
                    granted_next    = 1'b1;
                    state_next      = S_EMIT;
                end
                else if (cnt_plus1 >= lim)
                begin
                    res_status_next = ST_FULL;
                    res_grant_next  = '0;
                    res_en_next     = 1'b0;
                    state_next      = S_EMIT;
                end
                else
                begin
                    cmd.op   = CELL_SHIFT;
                    pos_next = (pos_plus1 >= lim) ? '0 : IDX_W'(pos_plus1);
                    cnt_next = cnt_plus1;
                end
            end

            S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_grant_next  = res_grant_reg;
                    out_en_next     = res_en_reg;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_reg      <= '0;
            granted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            granted_reg   <= granted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            r_type_reg  <= req_type_t'(req.req_type);
            r_any_reg   <= req.req_any;
            r_index_reg <= req.req_index;
            r_fc_reg    <= req.flow_ctrl;
            r_eq_reg    <= req.has_eq;
            r_busy_reg  <= req.lists_busy;
        end
        pos_reg        <= pos_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        res_en_reg     <= res_en_next;
        out_status_reg <= out_status_next;
        out_grant_reg  <= out_grant_next;
        out_en_reg     <= out_en_next;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/table_index_allocator_core.sv
// Top level: slot limit register, row of slot cells and the request sequencer.
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   req_type, req_any, req_index, flow_ctrl, has_eq, lists_busy
//  rsp      out  valid/ready   status, grant_index, entry_enabled
//  cfg      in   cfg_wr_en     cfg_wr_data (max_entries)
//
// One item at a time. Named allocate, free, enable and disable pass the exec and emit states
// into the output register; the next item is accepted once the sequencer is back in idle.
// Allocate-any searches up to the slot limit of cells; its token moves one cell per cycle.
// A stalled result holds the sequencer in its emit state; the next item is accepted
// once the result is loaded. Reset clears every slot at once; no clearing pass.
`default_nettype none
module table_index_allocator_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    tia_req_if.sink                        req,
    tia_rsp_if.source                      rsp,
    input  wire logic                      cfg_wr_en,
    input  wire logic [tia_pkg::CFG_W-1:0] cfg_wr_data
);
    import tia_pkg::*;

    logic [CFG_W-1:0]       max_entries_reg;
    logic [LIM_W-1:0]       lim;
    cell_cmd_t              cmd;
    cell_sum_t              sum;

    logic [NUM_ENTRIES-1:0] tok_in;
    logic [NUM_ENTRIES-1:0] tok_fwd;
    logic [NUM_ENTRIES-1:0] tok_wrap;
    logic [NUM_ENTRIES-1:0] sel_in_use;
    logic [NUM_ENTRIES-1:0] sel_en;
    logic [NUM_ENTRIES-1:0] tok_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_entries_reg <= MAX_ENTRIES_RST;
        else if (cfg_wr_en)
            max_entries_reg <= cfg_wr_data;
    end

    assign lim = (SEL_W'(max_entries_reg) >= SEL_W'(NUM_ENTRIES))
                 ? LIM_W'(NUM_ENTRIES) : LIM_W'(max_entries_reg);

    assign tok_in = {tok_fwd[NUM_ENTRIES-2:0], |tok_wrap};

    assign sum.sel_in_use = |sel_in_use;
    assign sum.sel_en     = |sel_en;
    assign sum.tok_free   = |tok_free;

    for (genvar g = 0; g < NUM_ENTRIES; g++)
    begin : g_cell
        tia_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (IDX_W'(g)),
            .lim        (lim),
            .cmd        (cmd),
            .tok_in     (tok_in[g]),
            .tok_fwd    (tok_fwd[g]),
            .tok_wrap   (tok_wrap[g]),
            .sel_in_use (sel_in_use[g]),
            .sel_en     (sel_en[g]),
            .tok_free   (tok_free[g])
        );
    end

    tia_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .lim   (lim),
        .sum   (sum),
        .cmd   (cmd)
    );

endmodule
`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the table index allocator core.
`timescale 1ns / 100ps
module testbench;
    import tia_pkg::*;

    localparam int CYCLE_LIMIT = 500_000;

    typedef struct {
        req_type_t  kind;
        bit         any;
        bit [7:0]   index;
        bit         fc;
        bit         eq;
        bit         busy;
    } request_t;

    typedef struct {
        status_t    status;
        bit [5:0]   slot;
        bit         enabled;
    } reply_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_W-1:0]     cfg_wr_data;

    tia_req_if req_ch ();
    tia_rsp_if rsp_ch ();

    table_index_allocator_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the slot table
    bit         slot_used [NUM_ENTRIES];
    bit         slot_en [NUM_ENTRIES];
    int         last_grant = 0;
    bit         granted_any = 1'b0;
    int         slot_limit = 64;

    request_t   queued_requests [$];
    reply_t     awaited_replies [$];

    int         send_gap_pct = 13;
    int         recv_stall_pct = 78;
    int         stall_left = 0;
    bit         req_taken = 1'b0;
    int         errors = 0;
    int         replies_checked = 0;
    int         limits_used = 1;
    int         status_count [5];
    longint     cycles = 0;

    request_t   offer;
    request_t   seen;
    reply_t     want;

    function automatic reply_t apply_to_table(request_t r);
        reply_t o;
        int     lim;
        int     idx;
        int     start;
        int     s;
        bit     hit;
        bit     found;
        lim = (slot_limit < NUM_ENTRIES) ? slot_limit : NUM_ENTRIES;
        idx = r.index;
        hit = idx < lim;
        found = 1'b0;
        s = 0;
        o.status = ST_OK;
        o.slot = '0;
        o.enabled = 1'b0;
        if (hit)
            o.enabled = slot_en[idx];
        if (r.kind == REQ_ALLOC)
        begin
            if (r.fc && !r.eq)
            begin
                o.status = ST_EQ_NEEDED;
            end
            else if (!r.any)
            begin
                if (!hit)
                begin
                    o.status = ST_INVALID;
                end
                else if (slot_used[idx])
                begin
                    o.status = ST_IN_USE;
                end
                else
                begin
                    s = idx;
                    found = 1'b1;
                end
            end
            else
            begin
                // next fit: resume just past the last grant, wrap at the limit
                start = (granted_any && last_grant + 1 < lim) ? last_grant + 1 : 0;
                for (int k = 0; k < lim && !found; k++)
                begin
                    s = start + k;
                    if (s >= lim)
                        s -= lim;
                    if (!slot_used[s])
                        found = 1'b1;
                end
                if (!found)
                begin
                    o.status = ST_FULL;
                    o.enabled = 1'b0;
                end
            end
            if (found)
            begin
                slot_used[s] = 1'b1;
                slot_en[s] = 1'b1;
                last_grant = s;
                granted_any = 1'b1;
                o.slot = 6'(s);
                o.enabled = 1'b1;
            end
        end
        else if (!hit || !slot_used[idx])
        begin
            o.status = ST_INVALID;
        end
        else if (r.kind == REQ_FREE && r.busy)
        begin
            o.status = ST_IN_USE;
        end
        else
        begin
            case (r.kind)
                REQ_FREE:
                begin
                    slot_used[idx] = 1'b0;
                    slot_en[idx] = 1'b0;
                end
                REQ_ENABLE: slot_en[idx] = 1'b1;
                default: slot_en[idx] = 1'b0;
            endcase
            o.enabled = slot_en[idx];
        end
        return o;
    endfunction

    function automatic request_t random_request(int lim);
        request_t r;
        int       top;
        int       pick;
        top = (lim < NUM_ENTRIES) ? lim : NUM_ENTRIES;
        pick = $urandom_range(99);
        if (pick < 40)
            r.kind = REQ_ALLOC;
        else if (pick < 65)
            r.kind = REQ_FREE;
        else if (pick < 82)
            r.kind = REQ_ENABLE;
        else
            r.kind = REQ_DISABLE;
        r.any = $urandom_range(1);
        // mostly near the live range, sometimes anywhere in the byte
        if ($urandom_range(9) < 8)
            r.index = 8'($urandom_range(top + 1));
        else
            r.index = 8'($urandom_range(255));
        r.fc = ($urandom_range(3) == 0);
        r.eq = ($urandom_range(9) < 7);
        r.busy = ($urandom_range(3) == 0);
        return r;
    endfunction

    function automatic void add(req_type_t kind, bit any, int index, bit fc, bit eq, bit busy);
        request_t r;
        r.kind = kind;
        r.any = any;
        r.index = 8'(index);
        r.fc = fc;
        r.eq = eq;
        r.busy = busy;
        queued_requests.push_back(r);
    endfunction

    task automatic report(string field, int exp_v, int act_v);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    endtask

    task automatic write_limit(int v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= CFG_W'(v);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        slot_limit = v;
        limits_used++;
    endtask

    task automatic set_pace(int send_pct, int recv_pct);
        @(posedge clk);
        send_gap_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic drain();
        while (queued_requests.size() != 0 || req_ch.valid || awaited_replies.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_ALLOC;
        req_ch.req_any = 1'b0;
        req_ch.req_index = '0;
        req_ch.flow_ctrl = 1'b0;
        req_ch.has_eq = 1'b0;
        req_ch.lists_busy = 1'b0;
        rsp_ch.ready = 1'b0;
    end

    // Sender: holds an item until taken, random gaps between items
    always @(negedge clk)
    begin
        if (rst_n && (!req_ch.valid || req_taken))
        begin
            if (queued_requests.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                offer = queued_requests.pop_front();
                req_ch.req_type <= offer.kind;
                req_ch.req_any <= offer.any;
                req_ch.req_index <= offer.index;
                req_ch.flow_ctrl <= offer.fc;
                req_ch.has_eq <= offer.eq;
                req_ch.lists_busy <= offer.busy;
                req_ch.valid <= 1'b1;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when stall_left is loaded
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        req_taken = req_ch.valid && req_ch.ready;
        if (rst_n)
        begin
            // check replies before queuing the new item's outcome
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    report("unexpected reply status", -1, rsp_ch.status);
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    replies_checked++;
                    status_count[want.status]++;
                    if (rsp_ch.status !== want.status)
                        report("status", want.status, rsp_ch.status);
                    if (rsp_ch.grant_index !== want.slot)
                        report("grant_index", want.slot, rsp_ch.grant_index);
                    if (rsp_ch.entry_enabled !== want.enabled)
                        report("entry_enabled", want.enabled, rsp_ch.entry_enabled);
                end
            end
            if (req_taken)
            begin
                seen.kind = req_type_t'(req_ch.req_type);
                seen.any = req_ch.req_any;
                seen.index = req_ch.req_index;
                seen.fc = req_ch.flow_ctrl;
                seen.eq = req_ch.has_eq;
                seen.busy = req_ch.lists_busy;
                awaited_replies.push_back(apply_to_table(seen));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d replies outstanding", $time, awaited_replies.size());
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        int limits [10] = '{5, 127, 1, 16, 0, 64, 2, 40, 65, 9};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset limit of 64
        add(REQ_ALLOC, 1, 0, 0, 0, 0);        // first search starts at slot 0
        add(REQ_ALLOC, 1, 0, 0, 0, 0);
        add(REQ_ALLOC, 0, 63, 0, 0, 0);       // top slot by name
        add(REQ_ALLOC, 1, 0, 0, 0, 0);        // search past top wraps to 0
        add(REQ_ALLOC, 0, 64, 0, 1, 0);
        add(REQ_ALLOC, 0, 255, 1, 1, 1);
        add(REQ_ALLOC, 0, 2, 0, 0, 0);        // already taken
        add(REQ_ALLOC, 1, 0, 1, 0, 0);        // flow control, no event queue
        add(REQ_ALLOC, 0, 10, 1, 1, 0);
        add(REQ_FREE, 0, 1, 0, 0, 1);         // lists still busy
        add(REQ_FREE, 0, 1, 0, 0, 0);
        add(REQ_FREE, 0, 1, 0, 0, 0);         // already free
        add(REQ_FREE, 1, 200, 1, 1, 0);
        add(REQ_DISABLE, 0, 0, 0, 0, 0);
        add(REQ_ENABLE, 0, 0, 0, 0, 0);
        add(REQ_ENABLE, 0, 5, 0, 0, 0);
        add(REQ_DISABLE, 0, 255, 0, 0, 0);
        add(REQ_ALLOC, 0, 0, 1, 0, 1);        // queue check comes before in-use
        drain();

        // zero limit: nothing addressable, any-allocate is full
        write_limit(0);
        add(REQ_ALLOC, 1, 0, 0, 1, 0);
        add(REQ_ALLOC, 0, 0, 0, 1, 0);
        add(REQ_ENABLE, 0, 0, 0, 0, 0);
        drain();

        // two slots: fill up, then full
        write_limit(2);
        add(REQ_ALLOC, 1, 0, 0, 0, 0);
        add(REQ_ALLOC, 1, 0, 0, 0, 0);
        add(REQ_FREE, 0, 10, 0, 0, 0);        // beyond lowered limit
        drain();

        for (int p = 0; p < 10; p++)
        begin
            if (p == 4)
                set_pace(78, 13);
            else if (p == 7)
                set_pace(0, 0);
            write_limit(limits[p]);
            if (p == 1)
            begin
                @(posedge clk);
                stall_left = 400;
            end
            repeat (98) queued_requests.push_back(random_request(limits[p]));
            drain();
        end

        repeat (80) @(posedge clk);
        $display("covered %0d requests under %0d slot limit settings, 0 through 127",
                 replies_checked, limits_used);
        $display("replies: %0d ok, %0d invalid, %0d in use, %0d full, %0d queue needed",
                 status_count[ST_OK], status_count[ST_INVALID], status_count[ST_IN_USE],
                 status_count[ST_FULL], status_count[ST_EQ_NEEDED]);
        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/tia_pkg.sv
hw/rtl/tia_if.sv
hw/rtl/tia_cell.sv
hw/rtl/tia_ctrl.sv
hw/rtl/table_index_allocator_core.sv
verif/testbench.sv
